// ===== sv/assert_macros.svh =====
// Assertion macros shared by the scaler modules.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ipr_pkg.sv =====
// Shared types, constants and helper functions for the pixel replication scaler.
// Used by ipr_front, ipr_back and the top level; depends on nothing.
package ipr_pkg;

	localparam int MAX_ROW_PIXELS = 4096;
	localparam int MAX_SCALE      = 100;
	localparam int ADDR_W         = $clog2(MAX_ROW_PIXELS);
	localparam int COL_W          = ADDR_W + 1;
	localparam int FACTOR_W       = 7;
	localparam int RGB_W          = 24;
	localparam int PAD_W          = 2;
	localparam int CFG_W          = 13;
	localparam int QDEPTH         = 4;
	localparam int QPTR_W         = $clog2(QDEPTH);
	localparam int QCNT_W         = QPTR_W + 1;

	// Command codes; also used as the phase the block expects next.
	typedef enum logic [0:0] {
		CMD_PIXEL = 1'b0,
		CMD_TICK  = 1'b1
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_SCALE = 1'b0,
		REG_ROW   = 1'b1
	} reg_idx_t;

	// One finished result transaction.
	typedef struct packed {
		logic [RGB_W-1:0]    rgb;
		logic [FACTOR_W-1:0] repeat_cnt;
		logic                row_end;
		logic [PAD_W-1:0]    pad;
		logic                expect_next;
		logic                bad_cmd;
	} result_t;

	// Classified item handed from the front to the back.
	typedef struct packed {
		logic    use_store;
		result_t res;
	} item_t;

	// Line store access issued by the front.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [RGB_W-1:0]  wdata;
	} ram_req_t;

	// Padding to bring row*factor*3 bytes to a multiple of four.
	// Only the low two bits of row length and factor matter.
	function automatic logic [PAD_W-1:0] pad_calc(input logic [1:0] r, input logic [1:0] f);
		logic [3:0] prod;
		logic [5:0] bytes;
		prod  = {2'b00, r} * {2'b00, f};
		bytes = {2'b00, prod} * 6'd3;
		return PAD_W'(3'd4 - {1'b0, bytes[1:0]});
	endfunction

endpackage

// ===== sv/ipr_ram.sv =====
// Generic single-port RAM with a registered read, read-before-write.
// Standalone; no package needed.
module ipr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read share one address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== sv/ipr_front.sv =====
// Front part: configuration registers, command classification, row/pass state
// and line store requests. Depends on ipr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ipr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic                       wr_index,
	input  logic [ipr_pkg::CFG_W-1:0]  wr_data,
	input  logic                       accept,
	input  logic                       cmd,
	input  logic [ipr_pkg::RGB_W-1:0]  rgb,
	output ipr_pkg::ram_req_t          ram_req,
	output logic                       item_valid,
	output ipr_pkg::item_t             item
);
	import ipr_pkg::*;

	logic [FACTOR_W-1:0] scale_q;
	logic [CFG_W-1:0]    rowpix_q;
	logic [ADDR_W-1:0]   column_q;
	logic [FACTOR_W-1:0] pass_q;
	cmd_t                phase_q;

	logic [FACTOR_W-1:0] eff_f;
	logic [COL_W-1:0]    eff_row;
	logic                match;
	logic [COL_W-1:0]    col_next;
	logic                last;
	logic [FACTOR_W:0]   pass_next;
	logic                pass_done;
	logic                step;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= FACTOR_W'(1);
			rowpix_q <= CFG_W'(1);
		end else if (wr_en) begin
			if (wr_index == REG_SCALE) begin
				scale_q <= wr_data[FACTOR_W-1:0];
			end else begin
				rowpix_q <= wr_data;
			end
		end
	end

	// Clamp the registers to their usable ranges.
	always_comb begin
		if (scale_q == '0) begin
			eff_f = FACTOR_W'(1);
		end else if (scale_q > FACTOR_W'(MAX_SCALE)) begin
			eff_f = FACTOR_W'(MAX_SCALE);
		end else begin
			eff_f = scale_q;
		end
		if (rowpix_q == '0) begin
			eff_row = COL_W'(1);
		end else if (COL_W'(rowpix_q) > COL_W'(MAX_ROW_PIXELS)) begin
			eff_row = COL_W'(MAX_ROW_PIXELS);
		end else begin
			eff_row = COL_W'(rowpix_q);
		end
	end

	// Classify the incoming transaction against the current phase.
	assign match     = (cmd_t'(cmd) == phase_q);
	assign step      = accept && match;
	assign col_next  = {1'b0, column_q} + COL_W'(1);
	assign last      = (col_next >= eff_row);
	assign pass_next = {1'b0, pass_q} + (FACTOR_W + 1)'(1);
	assign pass_done = (pass_next >= {1'b0, eff_f});

	// Column, replay pass and phase advance only on a matching command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			pass_q   <= '0;
			phase_q  <= CMD_PIXEL;
		end else if (step) begin
			if (last) begin
				column_q <= '0;
				if (pass_done) begin
					pass_q  <= '0;
					phase_q <= CMD_PIXEL;
				end else begin
					pass_q  <= pass_next[FACTOR_W-1:0];
					phase_q <= CMD_TICK;
				end
			end else begin
				column_q <= col_next[ADDR_W-1:0];
			end
		end
	end

	// Pixels are written to the store; ticks read the same column back.
	assign ram_req.we    = step && (phase_q == CMD_PIXEL);
	assign ram_req.addr  = column_q;
	assign ram_req.wdata = rgb;

	// Build the classified item for the back part.
	always_comb begin
		item = '0;
		if (!match) begin
			item.res.expect_next = phase_q;
			item.res.bad_cmd     = 1'b1;
		end else begin
			item.use_store      = (phase_q == CMD_TICK);
			item.res.rgb        = rgb;
			item.res.repeat_cnt = eff_f;
			item.res.row_end    = last;
			item.res.pad        = last ? pad_calc(eff_row[1:0], eff_f[1:0]) : '0;
			if (last) begin
				item.res.expect_next = !pass_done;
			end else begin
				item.res.expect_next = phase_q;
			end
		end
	end

	assign item_valid = accept;

	`ASSERT_NEXT(a_bad_cmd_keeps_state, accept && !match, $stable(column_q) && $stable(pass_q) && $stable(phase_q), "rejected command changed row state")
	`ASSERT_ALWAYS(a_pass_in_range, pass_q < FACTOR_W'(MAX_SCALE), "replay pass count out of range")

endmodule

// ===== sv/ipr_back.sv =====
// Back part: merges line store data into replayed runs and queues finished
// results for the consumer. Depends on ipr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ipr_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  ipr_pkg::item_t            item,
	input  logic [ipr_pkg::RGB_W-1:0] ram_rdata,
	input  logic                      pop,
	output logic                      full,
	output logic                      empty,
	output ipr_pkg::result_t          head
);
	import ipr_pkg::*;

	logic              valid_s1;
	item_t             item_s1;
	result_t           merged;
	result_t           fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;
	logic [QCNT_W:0]   pending;

	// Stage one waits for the registered store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
	end

	// Replayed runs take their pixel from the store.
	always_comb begin
		merged = item_s1.res;
		if (item_s1.use_store) begin
			merged.rgb = ram_rdata;
		end
	end

	assign do_pop = pop && !empty;

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fifo_q[wp_q] <= merged;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				wp_q <= wp_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(valid_s1) - QCNT_W'(do_pop);
		end
	end

	// Stop taking items once every slot is spoken for, the stage included.
	assign pending = {1'b0, cnt_q} + (QCNT_W + 1)'(valid_s1);
	assign full    = (pending >= (QCNT_W + 1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign head    = fifo_q[rp_q];

	`ASSERT_ALWAYS(a_no_overflow, pending <= (QCNT_W + 1)'(QDEPTH), "result queue overflow")
	`ASSERT_IMPLY(a_bad_has_no_repeat, valid_s1 && item_s1.res.bad_cmd, item_s1.res.repeat_cnt == '0, "rejected command carries a nonzero repeat")

endmodule

// ===== sv/integer_pixel_replication_scaler.sv =====
// Integer pixel replication scaler: takes one pixel or replay tick per clock
// while the queue has room and returns one run per transaction, registered
// in the read stage and then queued. The rate is one transaction per clock
// and is set by the single-port line store, which is written by a pixel or
// read by a tick in the accept cycle. At most four results are held between
// the read stage and the output queue. Full is high whenever four results
// are outstanding, whether or not the consumer pops in that cycle, so a
// consumer that pops every cycle never sees it. The line store is not
// cleared after reset. Depends on ipr_pkg, ipr_ram, ipr_front and ipr_back.
module integer_pixel_replication_scaler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic                          wr_index,
	input  logic [ipr_pkg::CFG_W-1:0]     wr_data,
	input  logic                          push,
	output logic                          full,
	input  logic                          cmd,
	input  logic [ipr_pkg::RGB_W-1:0]     rgb,
	output logic                          empty,
	input  logic                          pop,
	output logic [ipr_pkg::RGB_W-1:0]     out_rgb,
	output logic [ipr_pkg::FACTOR_W-1:0]  repeat_res,
	output logic                          row_end,
	output logic [ipr_pkg::PAD_W-1:0]     pad_bytes,
	output logic                          expect_next,
	output logic                          bad_cmd
);
	import ipr_pkg::*;

	logic             accept;
	ram_req_t         ram_req;
	logic [RGB_W-1:0] ram_rdata;
	logic             item_valid;
	item_t            item;
	result_t          head;

	// An input transaction is taken whenever the queue has room.
	assign accept = push && !full;

	ipr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.accept     (accept),
		.cmd        (cmd),
		.rgb        (rgb),
		.ram_req    (ram_req),
		.item_valid (item_valid),
		.item       (item)
	);

	ipr_ram #(
		.WIDTH (RGB_W),
		.DEPTH (MAX_ROW_PIXELS)
	) u_line_store (
		.clk   (clk),
		.we    (ram_req.we),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (ram_rdata)
	);

	ipr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.ram_rdata  (ram_rdata),
		.pop        (pop),
		.full       (full),
		.empty      (empty),
		.head       (head)
	);

	// Result fields come straight from the queue head.
	assign out_rgb     = head.rgb;
	assign repeat_res  = head.repeat_cnt;
	assign row_end     = head.row_end;
	assign pad_bytes   = head.pad;
	assign expect_next = head.expect_next;
	assign bad_cmd     = head.bad_cmd;

endmodule

// ===== verif/integer_pixel_replication_scaler_chk.sv =====
// Scoreboard for the pixel replication scaler. It predicts one run for every
// accepted input transaction and compares each popped run with the oldest one.
// Depends on ipr_pkg for the command, register index and result types.
`timescale 1ns / 100ps

module integer_pixel_replication_scaler_chk (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic                         wr_index,
	input  logic [ipr_pkg::CFG_W-1:0]    wr_data,
	input  logic                         push,
	input  logic                         full,
	input  logic                         cmd,
	input  logic [ipr_pkg::RGB_W-1:0]    rgb,
	input  logic                         empty,
	input  logic                         pop,
	input  logic [ipr_pkg::RGB_W-1:0]    out_rgb,
	input  logic [ipr_pkg::FACTOR_W-1:0] repeat_res,
	input  logic                         row_end,
	input  logic [ipr_pkg::PAD_W-1:0]    pad_bytes,
	input  logic                         expect_next,
	input  logic                         bad_cmd,
	output int                           fail_count,
	output int                           outstanding
);
	import ipr_pkg::*;

	// Mirror of the block's row memory, position and replay progress.
	logic [RGB_W-1:0]    row_mem [MAX_ROW_PIXELS];
	int unsigned         col_ptr;
	int unsigned         passes_done;
	cmd_t                phase;
	logic [FACTOR_W-1:0] scale_reg;
	logic [CFG_W-1:0]    row_len_reg;
	result_t             runs_due [$];
	result_t             seen_run;
	int                  errors;

	initial begin
		fail_count  = 0;
		outstanding = 0;
	end

	// Works out the run for one transaction and advances the mirrored state.
	function automatic result_t replicate_item(input cmd_t c, input logic [RGB_W-1:0] px);
		result_t     r;
		int unsigned f;
		int unsigned len;
		int unsigned idx;
		int unsigned bytes;
		f   = (scale_reg == 0) ? 1 : ((scale_reg > MAX_SCALE) ? MAX_SCALE : scale_reg);
		len = (row_len_reg == 0) ? 1 :
			((row_len_reg > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : row_len_reg);
		r = '0;
		// A command out of phase leaves everything as it was.
		if (c != phase) begin
			r.expect_next = phase;
			r.bad_cmd     = 1'b1;
			return r;
		end
		idx = (col_ptr >= MAX_ROW_PIXELS) ? MAX_ROW_PIXELS - 1 : col_ptr;
		if (phase == CMD_PIXEL) begin
			row_mem[idx] = px;
			r.rgb        = px;
		end else begin
			r.rgb = row_mem[idx];
		end
		r.repeat_cnt = FACTOR_W'(f);
		// The last column closes an output row and may end the replay.
		if (idx + 1 >= len) begin
			bytes     = len * f * 3;
			r.row_end = 1'b1;
			r.pad     = PAD_W'((4 - bytes % 4) % 4);
			col_ptr   = 0;
			passes_done++;
			if (passes_done >= f) begin
				passes_done = 0;
				phase       = CMD_PIXEL;
			end else begin
				phase = CMD_TICK;
			end
		end else begin
			col_ptr = idx + 1;
		end
		r.expect_next = phase;
		return r;
	endfunction

	// Counts a failure and reports the first few of them.
	task automatic note_mismatch(input string what, input result_t want, input result_t got);
		errors++;
		if (errors <= 10)
			$display("%0t chk: %s exp rgb=%h rep=%0d end=%b pad=%0d next=%b bad=%b",
				$realtime, what, want.rgb, want.repeat_cnt, want.row_end, want.pad,
				want.expect_next, want.bad_cmd);
		if (errors <= 10)
			$display("%0t chk: %s got rgb=%h rep=%0d end=%b pad=%0d next=%b bad=%b",
				$realtime, what, got.rgb, got.repeat_cnt, got.row_end, got.pad,
				got.expect_next, got.bad_cmd);
	endtask

	// Predict on input transactions, track register writes, check result transactions.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_ptr     = 0;
			passes_done = 0;
			phase       = CMD_PIXEL;
			scale_reg   = FACTOR_W'(1);
			row_len_reg = CFG_W'(1);
			errors      = 0;
			runs_due.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (push && !full)
				runs_due.push_back(replicate_item(cmd_t'(cmd), rgb));
			if (wr_en) begin
				if (reg_idx_t'(wr_index) == REG_SCALE)
					scale_reg = wr_data[FACTOR_W-1:0];
				else
					row_len_reg = wr_data;
			end
			if (pop && !empty) begin
				seen_run.rgb         = out_rgb;
				seen_run.repeat_cnt  = repeat_res;
				seen_run.row_end     = row_end;
				seen_run.pad         = pad_bytes;
				seen_run.expect_next = expect_next;
				seen_run.bad_cmd     = bad_cmd;
				if (runs_due.size() == 0)
					note_mismatch("unexpected run", '0, seen_run);
				else if (seen_run !== runs_due[0])
					note_mismatch("run mismatch", runs_due.pop_front(), seen_run);
				else
					void'(runs_due.pop_front());
			end
			fail_count  <= errors;
			outstanding <= runs_due.size();
		end
	end

endmodule

// ===== verif/integer_pixel_replication_scaler_tb.sv =====
// Testbench top for the pixel replication scaler: clock, reset, stimulus,
// register writes, result back-pressure and the verdict.
// Depends on ipr_pkg, the scaler RTL and integer_pixel_replication_scaler_chk.
`timescale 1ns / 100ps

module integer_pixel_replication_scaler_tb;
	import ipr_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 1450;
	localparam int NO_LIMIT     = 1 << 20;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                wr_en    = 1'b0;
	logic                wr_index = 1'b0;
	logic [CFG_W-1:0]    wr_data  = '0;
	logic                push     = 1'b0;
	logic                cmd      = 1'b0;
	logic [RGB_W-1:0]    rgb      = '0;
	logic                pop      = 1'b0;
	logic                full;
	logic                empty;
	logic [RGB_W-1:0]    out_rgb;
	logic [FACTOR_W-1:0] repeat_res;
	logic                row_end;
	logic [PAD_W-1:0]    pad_bytes;
	logic                expect_next;
	logic                bad_cmd;
	int                  fail_count;
	int                  outstanding;

	// Stimulus-side view of where the block is, used to build well-formed rows.
	cmd_t gen_phase   = CMD_PIXEL;
	int   gen_col     = 0;
	int   gen_pass    = 0;
	int   cur_scale   = 1;
	int   cur_row     = 1;
	int   sets_done   = 0;
	int   clean_items = 0;
	int   burst_left  = 0;
	int   idle_cycles = 0;
	int   pop_run     = 0;
	int   pop_mode    = 0;

	integer_pixel_replication_scaler u_dut (.*);

	integer_pixel_replication_scaler_chk u_chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int active_scale();
		return (cur_scale == 0) ? 1 : ((cur_scale > MAX_SCALE) ? MAX_SCALE : cur_scale);
	endfunction

	function automatic int active_row();
		return (cur_row == 0) ? 1 : ((cur_row > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : cur_row);
	endfunction

	// Sends one input transaction, with random gaps between bursts.
	task automatic send_item(input cmd_t c, input logic [RGB_W-1:0] px);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		push <= 1'b1;
		cmd  <= c;
		rgb  <= px;
		do @(posedge clk); while (full);
		// Follow the phase so that later items can be chosen in or out of it.
		if (c == gen_phase) begin
			clean_items++;
			if (gen_col + 1 >= active_row()) begin
				gen_col = 0;
				gen_pass++;
				if (gen_pass >= active_scale()) begin
					gen_pass  = 0;
					gen_phase = CMD_PIXEL;
					sets_done++;
				end else begin
					gen_phase = CMD_TICK;
				end
			end else begin
				gen_col++;
			end
		end
	endtask

	// Holds the input off until every predicted run has been popped.
	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= CFG_W'(val);
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		if (idx == REG_SCALE)
			cur_scale = val & 'h7F;
		else
			cur_row = val & 'h1FFF;
	endtask

	// Sends rows until the given number of full replication sets is done or
	// the item budget runs out; a few items go out of phase.
	task automatic run_phase(input int sets, input int max_items);
		int target;
		int n;
		target = sets_done + sets;
		n      = 0;
		while (sets_done < target && n < max_items) begin
			if ($urandom_range(0, 99) < 8)
				send_item(cmd_t'(~gen_phase), RGB_W'($urandom()));
			else
				send_item(gen_phase, RGB_W'($urandom()));
			n++;
		end
	endtask

	// Result side stalls on its own changing pattern.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop_run == 0) begin
				pop_mode = $urandom_range(0, 3);
				pop_run  = $urandom_range(16, 160);
			end
			pop_run--;
			case (pop_mode)
				0:       pop <= 1'b1;
				1:       pop <= 1'($urandom_range(0, 1));
				2:       pop <= ($urandom_range(0, 5) == 0);
				default: pop <= (pop_run % 9 == 0);
			endcase
		end
	end

	// Watchdog on cycles in which no transaction moves on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("integer_pixel_replication_scaler_tb: done, errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int target;
		int pick;
		int which;
		int scale_v;
		int row_v;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, black and white pixels and a tick out of phase.
		send_item(CMD_PIXEL, 24'h000000);
		send_item(CMD_PIXEL, 24'hFFFFFF);
		send_item(CMD_TICK, 24'h000000);
		wait_idle();

		// Zero factor and zero row length both act as one.
		write_reg(REG_SCALE, 0);
		write_reg(REG_ROW, 0);
		send_item(CMD_PIXEL, 24'hAAAAAA);
		send_item(CMD_TICK, 24'hFFFFFF);
		send_item(CMD_PIXEL, 24'h555555);
		wait_idle();

		// A short row replayed once, with a pixel sent during the replay.
		write_reg(REG_SCALE, 2);
		write_reg(REG_ROW, 3);
		send_item(CMD_PIXEL, 24'h123456);
		send_item(CMD_PIXEL, 24'hFF0000);
		send_item(CMD_PIXEL, 24'h00FF00);
		send_item(CMD_PIXEL, 24'h0F0F0F);
		repeat (3) send_item(CMD_TICK, 24'h000000);
		wait_idle();

		// Registers changed in the middle of a row and in the middle of a replay.
		write_reg(REG_SCALE, 3);
		write_reg(REG_ROW, 4);
		send_item(CMD_PIXEL, 24'h800001);
		send_item(CMD_PIXEL, 24'h7FFFFE);
		wait_idle();
		write_reg(REG_ROW, 2);
		send_item(CMD_PIXEL, 24'h00FFFF);
		send_item(CMD_TICK, 24'h000000);
		wait_idle();
		write_reg(REG_SCALE, 1);
		send_item(CMD_TICK, 24'h000000);
		wait_idle();

		// A full row of the longest random length, so that every column the
		// random rows can replay has been written.
		write_reg(REG_SCALE, 1);
		write_reg(REG_ROW, 64);
		run_phase(1, NO_LIMIT);
		wait_idle();

		// Oversized row saturates and must not end early.
		write_reg(REG_ROW, 8191);
		run_phase(NO_LIMIT, 40);
		wait_idle();

		// Largest factor, both exact and saturated.
		write_reg(REG_ROW, 1);
		write_reg(REG_SCALE, MAX_SCALE);
		run_phase(1, NO_LIMIT);
		wait_idle();
		write_reg(REG_SCALE, 127);
		run_phase(1, NO_LIMIT);

		// Random settings; mostly whole replication sets, some cut short.
		target = clean_items + RANDOM_ITEMS;
		while (clean_items < target) begin
			wait_idle();
			pick = $urandom_range(0, 15);
			if (pick == 0) begin
				scale_v = ($urandom_range(0, 1) == 0) ? MAX_SCALE : $urandom_range(0, 127);
				row_v   = $urandom_range(0, 3);
			end else if (pick == 1) begin
				scale_v = $urandom_range(1, 3);
				row_v   = $urandom_range(17, 64);
			end else begin
				scale_v = $urandom_range(0, 6);
				row_v   = $urandom_range(0, 16);
			end
			which = $urandom_range(0, 3);
			if (which != 2)
				write_reg(REG_SCALE, (int'($urandom_range(0, 63)) << FACTOR_W) | scale_v);
			if (which != 1)
				write_reg(REG_ROW, row_v);
			if ($urandom_range(0, 3) == 0)
				run_phase(NO_LIMIT, $urandom_range(1, 40));
			else
				run_phase($urandom_range(1, 3), NO_LIMIT);
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("integer_pixel_replication_scaler_tb: done, clean");
		else
			$display("integer_pixel_replication_scaler_tb: done, errors");
		$finish;
	end

endmodule
